>>> hdl/pfd_pkg.sv
// ----------------------------------------------------------------------------
// pfd_pkg: shared types of the packet frame decoder
// Frame status codes and the result item that leaves the decoder.
// ----------------------------------------------------------------------------
package pfd_pkg;

  // Frame status codes, in order of the reported outcome.
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SHORT = 3'd1,
    ST_SOF   = 3'd2,
    ST_BIG   = 3'd3,
    ST_CRC   = 3'd4
  } pfd_status_e;

  // Register indexes on the configuration port.
  localparam logic CFG_SOF_VALUE = 1'b0;
  localparam logic CFG_MAX_LEN   = 1'b1;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic [15:0] payload_length;
    logic [7:0]  sequence_res;
    logic [7:0]  command;
    pfd_status_e frame_status;
    logic [7:0]  payload_byte;
  } pfd_result_t;

endpackage

>>> hdl/pfd_out_skid.sv
// ----------------------------------------------------------------------------
// pfd_out_skid: output register with skid stage
// Holds result items for the master side so that the decoder keeps taking
// bytes while a result waits; the ready toward the decoder is registered.
// ----------------------------------------------------------------------------
module pfd_out_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_accept_i,
  input  pfd_pkg::pfd_result_t in_data_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pfd_pkg::pfd_result_t out_data_o
);

  logic                 main_valid_q;
  logic                 skid_valid_q;
  pfd_pkg::pfd_result_t main_q;
  pfd_pkg::pfd_result_t skid_q;
  logic                 push;

  // A result is only pushed when the upstream item is actually accepted.
  assign push = in_valid_i & in_accept_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!main_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        main_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_valid_q || out_ready_i) begin
      main_q <= skid_valid_q ? skid_q : in_data_i;
    end else if (push) begin
      skid_q <= in_data_i;
    end
  end

  assign in_ready_o  = ~skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

endmodule

>>> hdl/packet_frame_decoder_crc16.sv
// ----------------------------------------------------------------------------
// packet_frame_decoder_crc16: byte-stream frame decoder with CRC16-CCITT
// Parses SOF, little-endian length, command, sequence, payload and a
// little-endian CRC16-CCITT (poly 0x1021, init 0xFFFF over command, sequence
// and payload), passes payload bytes out and gives one status per buffer.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                   Contents
//  s_axis    in         s_axis_tvalid/tready        tdata: data_byte; tlast: last_byte
//  m_axis    out        m_axis_tvalid/tready        tdata: payload/status fields;
//                                                   tuser: result_kind
//  cfg       in         cfg_we_i (always taken)     idx 0 sof_value, idx 1 max_payload_len
//
// The decoder takes one byte per clock cycle while s_axis_tready is high. Each
// accepted byte updates the frame state and, if it causes a result, writes that
// result into the output register (or the skid stage while it is stalled) in the same edge.
// The byte-wide CRC update and the phase logic set the combinational path.
// A skid stage behind the output register keeps s_axis_tready high for one
// more item while a result is stalled; s_axis_tready drops only once both
// output slots are full. Reset is asynchronous, active low, and returns the
// frame state and both configuration registers to their reset values.
//
module packet_frame_decoder_crc16 (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] payload_byte, [10:8] frame_status, [18:11] command,
  // [26:19] sequence_res, [42:27] payload_length, [47:43] zero
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] result_kind
  // Configuration writes.
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [7:0]  SofReset = 8'hAA;
  localparam logic [15:0] MaxLenReset = 16'd512;

  typedef enum logic [2:0] {
    PH_SOF,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_CMD,
    PH_SEQ,
    PH_BODY,
    PH_CRC_HI
  } phase_e;

  // Byte-wide CRC16-CCITT update, MSB first.
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CrcPoly) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  // Configuration registers.
  logic [7:0]  sof_value_q;
  logic [15:0] max_len_q;

  // Frame state.
  phase_e      phase_q, phase_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  seq_q, seq_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic        sof_bad_q, sof_bad_d;
  logic        done_q, done_d;

  logic                 in_accept;
  logic                 res_valid;
  pfd_pkg::pfd_result_t res;
  pfd_pkg::pfd_result_t out_res;
  logic                 bad;
  logic                 status_now;
  logic [15:0]          rx_crc;

  // Build a status item from the holds as they stand.
  function automatic pfd_pkg::pfd_result_t mk_status(input pfd_pkg::pfd_status_e st,
                                                     input logic [7:0] c,
                                                     input logic [7:0] s,
                                                     input logic [15:0] l);
    pfd_pkg::pfd_result_t r;
    r.kind           = pfd_pkg::KIND_STATUS;
    r.payload_byte   = 8'd0;
    r.frame_status   = st;
    r.command        = (st == pfd_pkg::ST_OK) ? c : 8'd0;
    r.sequence_res   = (st == pfd_pkg::ST_OK) ? s : 8'd0;
    r.payload_length = (st == pfd_pkg::ST_OK || st == pfd_pkg::ST_BIG ||
                        st == pfd_pkg::ST_CRC) ? l : 16'd0;
    return r;
  endfunction

  assign in_accept = s_axis_tvalid & s_axis_tready;
  assign bad       = sof_bad_q | (len_q > max_len_q);
  assign rx_crc    = {s_axis_tdata, crc_lo_q};

  always_comb begin
    phase_d    = phase_q;
    crc_d      = crc_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    cmd_d      = cmd_q;
    seq_d      = seq_q;
    crc_lo_d   = crc_lo_q;
    sof_bad_d  = sof_bad_q;
    done_d     = done_q;
    status_now = 1'b0;
    res_valid  = 1'b0;
    res        = mk_status(pfd_pkg::ST_SHORT, cmd_q, seq_q, len_q);

    if (!done_q) begin
      case (phase_q)
        PH_LEN_LO: begin
          len_d   = {8'd0, s_axis_tdata};
          phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_d   = {s_axis_tdata, len_q[7:0]};
          phase_d = PH_CMD;
        end
        PH_CMD: begin
          cmd_d   = s_axis_tdata;
          crc_d   = crc_step(crc_q, s_axis_tdata);
          phase_d = PH_SEQ;
        end
        PH_SEQ: begin
          seq_d   = s_axis_tdata;
          crc_d   = crc_step(crc_q, s_axis_tdata);
          cnt_d   = 16'd0;
          phase_d = PH_BODY;
        end
        PH_BODY: begin
          if (bad) begin
            // The first body byte of a bad frame is swallowed; the next one
            // carries the bad-SOF or too-big status.
            if (cnt_q != 16'd0) begin
              res = mk_status(sof_bad_q ? pfd_pkg::ST_SOF : pfd_pkg::ST_BIG,
                              cmd_q, seq_q, len_q);
              status_now = 1'b1;
            end else begin
              cnt_d = 16'd1;
            end
          end else if (cnt_q < len_q) begin
            crc_d              = crc_step(crc_q, s_axis_tdata);
            cnt_d              = cnt_q + 16'd1;
            res.kind           = pfd_pkg::KIND_PAYLOAD;
            res.payload_byte   = s_axis_tdata;
            res.frame_status   = pfd_pkg::ST_OK;
            res.command        = 8'd0;
            res.sequence_res   = 8'd0;
            res.payload_length = 16'd0;
            res_valid          = 1'b1;
          end else begin
            crc_lo_d = s_axis_tdata;
            phase_d  = PH_CRC_HI;
          end
        end
        PH_CRC_HI: begin
          if (bad) begin
            res = mk_status(sof_bad_q ? pfd_pkg::ST_SOF : pfd_pkg::ST_BIG,
                            cmd_q, seq_q, len_q);
          end else begin
            res = mk_status((rx_crc == crc_q) ? pfd_pkg::ST_OK : pfd_pkg::ST_CRC,
                            cmd_q, seq_q, len_q);
          end
          status_now = 1'b1;
        end
        PH_SOF: begin
          sof_bad_d = (s_axis_tdata != sof_value_q);
          crc_d     = CrcInit;
          phase_d   = PH_LEN_LO;
        end
        default: begin
          phase_d = PH_SOF;
        end
      endcase

      if (status_now) begin
        done_d    = 1'b1;
        res_valid = 1'b1;
      end else if (s_axis_tlast) begin
        // The buffer ended before any outcome: a short status takes the item,
        // even if the byte would otherwise have been a payload byte.
        res       = mk_status(pfd_pkg::ST_SHORT, cmd_d, seq_d, len_d);
        res_valid = 1'b1;
      end
    end

    // The last byte of a buffer always returns the frame to its start.
    if (s_axis_tlast) begin
      phase_d   = PH_SOF;
      crc_d     = CrcInit;
      len_d     = 16'd0;
      cnt_d     = 16'd0;
      cmd_d     = 8'd0;
      seq_d     = 8'd0;
      crc_lo_d  = 8'd0;
      sof_bad_d = 1'b0;
      done_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SOF;
      crc_q     <= CrcInit;
      len_q     <= 16'd0;
      cnt_q     <= 16'd0;
      cmd_q     <= 8'd0;
      seq_q     <= 8'd0;
      crc_lo_q  <= 8'd0;
      sof_bad_q <= 1'b0;
      done_q    <= 1'b0;
    end else if (in_accept) begin
      phase_q   <= phase_d;
      crc_q     <= crc_d;
      len_q     <= len_d;
      cnt_q     <= cnt_d;
      cmd_q     <= cmd_d;
      seq_q     <= seq_d;
      crc_lo_q  <= crc_lo_d;
      sof_bad_q <= sof_bad_d;
      done_q    <= done_d;
    end
  end

  // Configuration registers take a write on every enabled edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sof_value_q <= SofReset;
      max_len_q   <= MaxLenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pfd_pkg::CFG_SOF_VALUE: sof_value_q <= cfg_data_i[7:0];
        pfd_pkg::CFG_MAX_LEN:   max_len_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pfd_out_skid u_out_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_accept_i (in_accept),
    .in_data_i   (res),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = {5'd0, out_res.payload_length, out_res.sequence_res,
                         out_res.command, out_res.frame_status, out_res.payload_byte};
  assign m_axis_tuser = out_res.kind;

endmodule
